// ===== design/sghbe_pkg.sv =====
// Shared types, codes, defaults and the saturating adder of the hat basis evaluator.
package sghbe_pkg;

    localparam int DEF_GRID_POINTS = 1024;
    localparam int DEF_MAX_DIMS    = 8;
    localparam int DEF_COORD_BITS  = 16;

    localparam int ACC_W  = 48;
    localparam int VAL_W  = 32;
    localparam int TERM_W = VAL_W + 2;

    localparam logic [2:0] FUNC_LOAD_LEVEL = 3'd0;
    localparam logic [2:0] FUNC_LOAD_COEF  = 3'd1;
    localparam logic [2:0] FUNC_MULT       = 3'd2;
    localparam logic [2:0] FUNC_TRANSPOSE  = 3'd3;
    localparam logic [2:0] FUNC_READ_ACC   = 3'd4;
    localparam logic [2:0] FUNC_CLEAR_ACC  = 3'd5;

    localparam logic CFG_GRID_COUNT = 1'b0;
    localparam logic CFG_DIM_COUNT  = 1'b1;

    typedef struct packed {
        logic wr_so;
        logic wr_coef;
        logic wr_coord;
        logic latch_in;
        logic sum_clr;
        logic b_init;
        logic diff;
        logic hat;
        logic bmul;
        logic tmul;
        logic use_coef;
        logic acc_mult;
        logic acc_trn;
        logic clr_wr;
        logic rb_sel;
        logic emit_mult;
        logic emit_rb;
    } t_cmd;

    function automatic logic signed [ACC_W-1:0] sat_add48(
        input logic signed [ACC_W-1:0]  a,
        input logic signed [TERM_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + (ACC_W+1)'(b);
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

// ===== design/sparse_grid_hat_basis_eval.sv =====
// Top level of the sparse grid linear hat basis evaluator.
// Loads, coordinates without the last-dimension flag and unknown codes leave busy low. Completing
// a data point sweeps the grid points in use one after another through one shared multiplier
// path, and a mult sweep ends by emitting the sum. A readback passes through a read and an
// output state, a clear zeroes every accumulator, and after reset the accumulators are
// cleared in a pass over all GRID_POINTS entries during which busy is high. Results come as
// one-cycle o_valid pulses and cannot be held off; configuration writes are always ready.
module sparse_grid_hat_basis_eval #(
    parameter int GRID_POINTS = sghbe_pkg::DEF_GRID_POINTS,
    parameter int MAX_DIMS    = sghbe_pkg::DEF_MAX_DIMS,
    parameter int COORD_BITS  = sghbe_pkg::DEF_COORD_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_func,
    input  logic [9:0]         i_grid_point,
    input  logic [2:0]         i_dimension,
    input  logic [15:0]        i_coordinate,
    input  logic [16:0]        i_level_scale,
    input  logic [15:0]        i_level_offset,
    input  logic signed [31:0] i_value,
    input  logic               i_last_dim,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [10:0]        i_cfg_data,
    output logic               o_valid,
    output logic               o_kind,
    output logic signed [47:0] o_result_value,
    output logic [9:0]         o_result_grid_point
);
    import sghbe_pkg::*;

    localparam int GCW = $clog2(GRID_POINTS + 1);
    localparam int DCW = $clog2(MAX_DIMS + 1);

    t_cmd           cmd;
    logic [GCW-1:0] g;
    logic [DCW-1:0] d;

    sghbe_ctrl #(
        .GRID_POINTS(GRID_POINTS),
        .MAX_DIMS(MAX_DIMS),
        .GCW(GCW),
        .DCW(DCW)
    ) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_func(i_func),
        .i_last_dim(i_last_dim),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_cmd(cmd),
        .o_g(g),
        .o_d(d)
    );

    sghbe_dp #(
        .GRID_POINTS(GRID_POINTS),
        .MAX_DIMS(MAX_DIMS),
        .COORD_BITS(COORD_BITS),
        .GCW(GCW),
        .DCW(DCW)
    ) u_dp (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd(cmd),
        .i_g(g),
        .i_d(d),
        .i_grid_point(i_grid_point),
        .i_dimension(i_dimension),
        .i_coordinate(i_coordinate),
        .i_level_scale(i_level_scale),
        .i_level_offset(i_level_offset),
        .i_value(i_value),
        .o_valid(o_valid),
        .o_kind(o_kind),
        .o_result_value(o_result_value),
        .o_result_grid_point(o_result_grid_point)
    );

endmodule

// ===== design/sghbe_ctrl.sv =====
// Controller state machine that sequences loads, evaluation sweeps, readback and clearing.
module sghbe_ctrl #(
    parameter int GRID_POINTS = sghbe_pkg::DEF_GRID_POINTS,
    parameter int MAX_DIMS    = sghbe_pkg::DEF_MAX_DIMS,
    parameter int GCW = $clog2(GRID_POINTS + 1),
    parameter int DCW = $clog2(MAX_DIMS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_func,
    input  logic              i_last_dim,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [10:0]       i_cfg_data,
    output sghbe_pkg::t_cmd   o_cmd,
    output logic [GCW-1:0]    o_g,
    output logic [DCW-1:0]    o_d
);
    import sghbe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_BINIT, S_DIFF, S_HAT, S_BMUL, S_TMUL, S_ACC, S_OUT, S_RBRD, S_RBOUT
    } t_state;

    t_state         r_state, n_state;
    logic [GCW-1:0] r_g, n_g;
    logic [DCW-1:0] r_d, n_d;
    logic           r_mult, n_mult;
    logic [10:0]    r_grid_count;
    logic [3:0]     r_dim_count;
    logic [GCW-1:0] ng;
    logic [DCW-1:0] nd;
    logic           take;
    t_cmd           cmd;

    assign ng = (32'(r_grid_count) > GRID_POINTS) ? GCW'(GRID_POINTS) : GCW'(r_grid_count);
    assign nd = (32'(r_dim_count) > MAX_DIMS) ? DCW'(MAX_DIMS) : DCW'(r_dim_count);
    assign busy = (r_state != S_IDLE);
    assign take = start && (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_cmd = cmd;
    assign o_g = r_g;
    assign o_d = r_d;

    always_comb begin
        n_state = r_state;
        n_g = r_g;
        n_d = r_d;
        n_mult = r_mult;
        cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (i_func)
                        FUNC_LOAD_LEVEL: cmd.wr_so = 1'b1;
                        FUNC_LOAD_COEF:  cmd.wr_coef = 1'b1;
                        FUNC_MULT, FUNC_TRANSPOSE: begin
                            cmd.wr_coord = 1'b1;
                            cmd.latch_in = 1'b1;
                            if (i_last_dim) begin
                                n_mult = (i_func == FUNC_MULT);
                                cmd.sum_clr = 1'b1;
                                n_g = '0;
                                n_d = '0;
                                if (ng == '0) begin
                                    n_state = (i_func == FUNC_MULT) ? S_OUT : S_IDLE;
                                end else begin
                                    n_state = S_BINIT;
                                end
                            end
                        end
                        FUNC_READ_ACC: begin
                            cmd.latch_in = 1'b1;
                            n_state = S_RBRD;
                        end
                        FUNC_CLEAR_ACC: begin
                            n_g = '0;
                            n_state = S_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLR: begin
                cmd.clr_wr = 1'b1;
                if (r_g == GCW'(GRID_POINTS - 1)) begin
                    n_g = '0;
                    n_state = S_IDLE;
                end else begin
                    n_g = GCW'(r_g + 1'b1);
                end
            end
            S_BINIT: begin
                cmd.b_init = 1'b1;
                n_state = (nd == '0) ? S_TMUL : S_DIFF;
            end
            S_DIFF: begin
                cmd.diff = 1'b1;
                n_state = S_HAT;
            end
            S_HAT: begin
                cmd.hat = 1'b1;
                n_d = DCW'(r_d + 1'b1);
                n_state = S_BMUL;
            end
            S_BMUL: begin
                cmd.bmul = 1'b1;
                n_state = (r_d == nd) ? S_TMUL : S_DIFF;
            end
            S_TMUL: begin
                cmd.tmul = 1'b1;
                cmd.use_coef = r_mult;
                n_state = S_ACC;
            end
            S_ACC: begin
                cmd.acc_mult = r_mult;
                cmd.acc_trn = !r_mult;
                n_d = '0;
                if (GCW'(r_g + 1'b1) == ng) begin
                    n_state = r_mult ? S_OUT : S_IDLE;
                end else begin
                    n_g = GCW'(r_g + 1'b1);
                    n_state = S_BINIT;
                end
            end
            S_OUT: begin
                cmd.emit_mult = 1'b1;
                n_state = S_IDLE;
            end
            S_RBRD: begin
                cmd.rb_sel = 1'b1;
                n_state = S_RBOUT;
            end
            S_RBOUT: begin
                cmd.rb_sel = 1'b1;
                cmd.emit_rb = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_g <= '0;
            r_d <= '0;
            r_mult <= 1'b0;
            r_grid_count <= 11'd1;
            r_dim_count <= 4'd1;
        end else begin
            r_state <= n_state;
            r_g <= n_g;
            r_d <= n_d;
            r_mult <= n_mult;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_GRID_COUNT) begin
                    r_grid_count <= i_cfg_data;
                end else begin
                    r_dim_count <= i_cfg_data[3:0];
                end
            end
        end
    end

    a_hat_then_bmul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_HAT |=> r_state == S_BMUL)
        else $error("hat step not followed by basis multiply");
    a_dim_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIFF |-> r_d < nd)
        else $error("dimension counter past dimension count");
    a_grid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ACC |-> r_g < ng)
        else $error("grid counter past grid count");
    a_out_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> r_mult)
        else $error("mult result emitted outside mult mode");

endmodule

// ===== design/sghbe_dp.sv =====
// Datapath with the level, coefficient and accumulator memories and the basis arithmetic.
module sghbe_dp #(
    parameter int GRID_POINTS = sghbe_pkg::DEF_GRID_POINTS,
    parameter int MAX_DIMS    = sghbe_pkg::DEF_MAX_DIMS,
    parameter int COORD_BITS  = sghbe_pkg::DEF_COORD_BITS,
    parameter int GCW = $clog2(GRID_POINTS + 1),
    parameter int DCW = $clog2(MAX_DIMS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sghbe_pkg::t_cmd       i_cmd,
    input  logic [GCW-1:0]        i_g,
    input  logic [DCW-1:0]        i_d,
    input  logic [9:0]            i_grid_point,
    input  logic [2:0]            i_dimension,
    input  logic [15:0]           i_coordinate,
    input  logic [16:0]           i_level_scale,
    input  logic [15:0]           i_level_offset,
    input  logic signed [31:0]    i_value,
    output logic                  o_valid,
    output logic                  o_kind,
    output logic signed [47:0]    o_result_value,
    output logic [9:0]            o_result_grid_point
);
    import sghbe_pkg::*;

    localparam int GW = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;
    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int AW = (GRID_POINTS * MAX_DIMS > 1) ? $clog2(GRID_POINTS * MAX_DIMS) : 1;
    localparam int XW = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int PW = 17 + XW;
    localparam int OW = 16 + COORD_BITS;
    localparam int TW = ((PW > OW) ? PW : OW) + 1;
    localparam int BW = COORD_BITS + 1;
    localparam int MW = VAL_W + BW + 1;

    logic [16:0]              scale_mem [GRID_POINTS*MAX_DIMS];
    logic [15:0]              offset_mem [GRID_POINTS*MAX_DIMS];
    logic signed [VAL_W-1:0]  coef_mem [GRID_POINTS];
    logic signed [ACC_W-1:0]  acc_mem [GRID_POINTS];
    logic [XW-1:0]            r_coord [MAX_DIMS];

    logic [16:0]              r_scale_q;
    logic [15:0]              r_offset_q;
    logic signed [VAL_W-1:0]  r_coef_q;
    logic signed [ACC_W-1:0]  r_acc_q;
    logic signed [TW-1:0]     r_t;
    logic [BW-1:0]            r_h;
    logic [BW-1:0]            r_b;
    logic signed [TERM_W-1:0] r_term;
    logic signed [ACC_W-1:0]  r_sum;
    logic signed [VAL_W-1:0]  r_weight;
    logic [9:0]               r_rb_gp;
    logic                     r_rb_ok;

    logic [GW-1:0]            g_idx;
    logic [DW-1:0]            d_idx;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic [GW-1:0]            acc_raddr;
    logic                     gp_ok;
    logic                     dim_ok;
    logic signed [TW-1:0]     n_t;
    logic [TW-1:0]            t_abs;
    logic signed [MW-1:0]     prod;
    logic [2*BW-1:0]          bprod;

    assign g_idx = GW'(i_g);
    assign d_idx = DW'(i_d);
    assign rd_addr = AW'(g_idx) * AW'(MAX_DIMS) + AW'(d_idx);
    assign wr_addr = AW'(GW'(i_grid_point)) * AW'(MAX_DIMS) + AW'(DW'(i_dimension));
    assign gp_ok = 32'(i_grid_point) < GRID_POINTS;
    assign dim_ok = 32'(i_dimension) < MAX_DIMS;
    assign acc_raddr = i_cmd.rb_sel ? GW'(r_rb_gp) : g_idx;

    assign n_t = $signed(TW'(r_scale_q * PW'(r_coord[d_idx])))
               - $signed(TW'(r_offset_q) << COORD_BITS);
    assign t_abs = r_t[TW-1] ? TW'(-r_t) : TW'(r_t);
    assign bprod = (2*BW)'(r_b) * (2*BW)'(r_h);
    assign prod = $signed(MW'(i_cmd.use_coef ? r_coef_q : r_weight))
                * $signed(MW'({1'b0, r_b}));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_so && gp_ok && dim_ok) begin
            scale_mem[wr_addr] <= i_level_scale;
            offset_mem[wr_addr] <= i_level_offset;
        end
        r_scale_q <= scale_mem[rd_addr];
        r_offset_q <= offset_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_coef && gp_ok) begin
            coef_mem[GW'(i_grid_point)] <= i_value;
        end
        r_coef_q <= coef_mem[g_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            acc_mem[g_idx] <= '0;
        end else if (i_cmd.acc_trn) begin
            acc_mem[g_idx] <= sat_add48(r_acc_q, r_term);
        end
        r_acc_q <= acc_mem[acc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_coord && dim_ok) begin
            r_coord[DW'(i_dimension)] <= i_coordinate[XW-1:0];
        end
        if (i_cmd.latch_in) begin
            r_weight <= i_value;
            r_rb_gp <= i_grid_point;
            r_rb_ok <= gp_ok;
        end
        if (i_cmd.diff) begin
            r_t <= n_t;
        end
        if (i_cmd.hat) begin
            r_h <= (t_abs < (TW'(1) << COORD_BITS)) ? BW'((TW'(1) << COORD_BITS) - t_abs) : '0;
        end
        if (i_cmd.b_init) begin
            r_b <= BW'(1) << COORD_BITS;
        end else if (i_cmd.bmul) begin
            r_b <= BW'(bprod >> COORD_BITS);
        end
        if (i_cmd.tmul) begin
            r_term <= TERM_W'(prod >>> COORD_BITS);
        end
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end else if (i_cmd.acc_mult) begin
            r_sum <= sat_add48(r_sum, r_term);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit_mult || i_cmd.emit_rb;
        end
        if (i_cmd.emit_rb) begin
            o_kind <= 1'b1;
            o_result_value <= r_rb_ok ? r_acc_q : '0;
            o_result_grid_point <= r_rb_gp;
        end else if (i_cmd.emit_mult) begin
            o_kind <= 1'b0;
            o_result_value <= r_sum;
            o_result_grid_point <= '0;
        end
    end

endmodule

// ===== verif/sghbe_checker.sv =====
// Checker that predicts and compares the results of the hat basis evaluator.
`timescale 1ns / 100ps

module sghbe_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         i_func,
    input  logic [9:0]         i_grid_point,
    input  logic [2:0]         i_dimension,
    input  logic [15:0]        i_coordinate,
    input  logic [16:0]        i_level_scale,
    input  logic [15:0]        i_level_offset,
    input  logic signed [31:0] i_value,
    input  logic               i_last_dim,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [10:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic               i_kind,
    input  logic signed [47:0] i_result_value,
    input  logic [9:0]         i_result_grid_point,
    output int                 o_failures,
    output int                 o_pending
);
    import sghbe_pkg::*;

    localparam int  NPTS      = DEF_GRID_POINTS;
    localparam int  NDIMS     = DEF_MAX_DIMS;
    localparam int  FRAC      = DEF_COORD_BITS;
    localparam bit  KIND_MULT = 1'b0;
    localparam bit  KIND_READ = 1'b1;
    localparam longint SUM_MAX = 64'sd140737488355327;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    typedef struct {
        bit        kind;
        longint    value;
        bit [9:0]  grid_point;
    } t_hat_result;

    t_hat_result    expected_results[$];
    logic [10:0]    grid_in_use;
    logic [3:0]     dims_in_use;
    logic [15:0]    coord_buf[NDIMS];
    logic [16:0]    scale_mem[NPTS*NDIMS];
    logic [15:0]    offset_mem[NPTS*NDIMS];
    logic [31:0]    coef_mem[NPTS];
    longint         acc_mem[NPTS];

    function automatic longint sat_sum48(longint a, longint b);
        longint s;
        s = a + b;
        if (s > SUM_MAX) return SUM_MAX;
        if (s < SUM_MIN) return SUM_MIN;
        return s;
    endfunction

    function automatic longint hat_product(int g, int nd);
        longint b;
        longint t;
        longint h;
        b = 64'sd1 << FRAC;
        for (int d = 0; d < nd; d++) begin
            t = longint'(scale_mem[g*NDIMS+d]) * longint'(coord_buf[d])
                - (longint'(offset_mem[g*NDIMS+d]) << FRAC);
            if (t < 0) t = -t;
            h = (t < (64'sd1 << FRAC)) ? (64'sd1 << FRAC) - t : 0;
            b = (b * h) >>> FRAC;
        end
        return b;
    endfunction

    initial begin
        o_failures = 0;
        o_pending  = 0;
    end

    always @(posedge i_clk) begin
        t_hat_result exp_r;
        int          ng;
        int          nd;
        longint      sum;
        if (!i_rst_n) begin
            grid_in_use = 11'd1;
            dims_in_use = 4'd1;
            for (int g = 0; g < NPTS; g++) acc_mem[g] = 0;
            expected_results.delete();
        end else begin
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    o_failures++;
                    if (o_failures <= 10)
                        $display("ERROR: unexpected result kind=%0d value=%0d gp=%0d",
                                 i_kind, i_result_value, i_result_grid_point);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_kind !== exp_r.kind || i_result_value !== exp_r.value[47:0]
                        || i_result_grid_point !== exp_r.grid_point) begin
                        o_failures++;
                        if (o_failures <= 10)
                            $display({"ERROR: expected kind=%0d value=%0d gp=%0d, ",
                                      "got kind=%0d value=%0d gp=%0d"},
                                     exp_r.kind, exp_r.value, exp_r.grid_point,
                                     i_kind, i_result_value, i_result_grid_point);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_GRID_COUNT) grid_in_use = i_cfg_data;
                else dims_in_use = i_cfg_data[3:0];
            end
            if (start && !busy) begin
                ng = (grid_in_use > NPTS) ? NPTS : grid_in_use;
                nd = (dims_in_use > NDIMS) ? NDIMS : dims_in_use;
                case (i_func)
                    FUNC_LOAD_LEVEL: begin
                        scale_mem[i_grid_point*NDIMS+i_dimension]  = i_level_scale;
                        offset_mem[i_grid_point*NDIMS+i_dimension] = i_level_offset;
                    end
                    FUNC_LOAD_COEF: coef_mem[i_grid_point] = i_value;
                    FUNC_MULT, FUNC_TRANSPOSE: begin
                        coord_buf[i_dimension] = i_coordinate;
                        if (i_last_dim) begin
                            if (i_func == FUNC_MULT) begin
                                sum = 0;
                                for (int g = 0; g < ng; g++)
                                    sum = sat_sum48(sum, (longint'($signed(coef_mem[g]))
                                                    * hat_product(g, nd)) >>> FRAC);
                                exp_r.kind       = KIND_MULT;
                                exp_r.value      = sum;
                                exp_r.grid_point = '0;
                                expected_results.push_back(exp_r);
                            end else begin
                                for (int g = 0; g < ng; g++)
                                    acc_mem[g] = sat_sum48(acc_mem[g], (longint'(i_value)
                                                 * hat_product(g, nd)) >>> FRAC);
                            end
                        end
                    end
                    FUNC_READ_ACC: begin
                        exp_r.kind       = KIND_READ;
                        exp_r.value      = acc_mem[i_grid_point];
                        exp_r.grid_point = i_grid_point;
                        expected_results.push_back(exp_r);
                    end
                    FUNC_CLEAR_ACC: for (int g = 0; g < NPTS; g++) acc_mem[g] = 0;
                    default: ;
                endcase
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the testbench: clock, reset, stimulus and verdict for the hat basis evaluator.
`timescale 1ns / 100ps

module testbench;
    import sghbe_pkg::*;

    localparam int LOADED_POINTS = 32;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_func;
    logic [9:0]         i_grid_point;
    logic [2:0]         i_dimension;
    logic [15:0]        i_coordinate;
    logic [16:0]        i_level_scale;
    logic [15:0]        i_level_offset;
    logic signed [31:0] i_value;
    logic               i_last_dim;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [10:0]        i_cfg_data;
    logic               o_valid;
    logic               o_kind;
    logic signed [47:0] o_result_value;
    logic [9:0]         o_result_grid_point;
    int                 failures;
    int                 pending;
    bit                 gaps_on;
    int                 grid_now;
    int                 dims_now;

    sparse_grid_hat_basis_eval dut (.*);

    sghbe_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_func, .i_grid_point, .i_dimension,
        .i_coordinate, .i_level_scale, .i_level_offset, .i_value, .i_last_dim,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_valid(o_valid), .i_kind(o_kind), .i_result_value(o_result_value),
        .i_result_grid_point(o_result_grid_point),
        .o_failures(failures), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send(input logic [2:0] func, input logic [9:0] gp, input logic [2:0] dim,
                        input logic [15:0] coord, input logic [16:0] scale,
                        input logic [15:0] offs, input logic [31:0] val, input logic last);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_func         <= func;
        i_grid_point   <= gp;
        i_dimension    <= dim;
        i_coordinate   <= coord;
        i_level_scale  <= scale;
        i_level_offset <= offs;
        i_value        <= val;
        i_last_dim     <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_counts(input int g, input int d);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_GRID_COUNT;
        i_cfg_data  <= 11'(g);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= CFG_DIM_COUNT;
        i_cfg_data  <= 11'(d);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        grid_now = g;
        dims_now = d;
    endtask

    // Mostly true hat functions centered on a dyadic grid, sometimes arbitrary ones.
    task automatic random_level(input logic [9:0] gp, input logic [2:0] dim);
        int          lvl;
        logic [16:0] s;
        logic [15:0] o;
        if ($urandom_range(0, 3) != 0) begin
            lvl = $urandom_range(0, 5);
            s   = 17'(1) << lvl;
            o   = 16'($urandom_range(0, 1 << lvl));
        end else begin
            s = 17'($urandom_range(1, 65536));
            o = 16'((longint'(s) * $urandom_range(0, 65535)) >> 16);
        end
        send(FUNC_LOAD_LEVEL, gp, dim, 16'($urandom), s, o, $urandom, 1'($urandom));
    endtask

    // Coordinates for every dimension in use, the last one completing the data point.
    task automatic data_point(input logic [2:0] func, input logic [31:0] weight,
                              input int coord_mode);
        int          n;
        logic [15:0] c;
        n = (dims_now > 8) ? 8 : ((dims_now < 1) ? 1 : dims_now);
        for (int d = 0; d < n; d++) begin
            c = (coord_mode == 1) ? 16'd0 : (coord_mode == 2) ? 16'hFFFF : 16'($urandom);
            send(func, 10'($urandom), 3'(d), c, 17'($urandom), 16'($urandom), weight,
                 d == n - 1);
        end
    endtask

    task automatic random_item();
        int          r;
        logic [2:0]  f;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            f = ($urandom_range(0, 1) == 0) ? FUNC_MULT : FUNC_TRANSPOSE;
            data_point(f, $urandom, 0);
        end else if (r < 65) begin
            random_level(10'($urandom), 3'($urandom));
        end else if (r < 72) begin
            send(FUNC_LOAD_COEF, 10'($urandom), 3'($urandom), 16'($urandom),
                 17'($urandom), 16'($urandom), $urandom, 1'($urandom));
        end else if (r < 85) begin
            send(FUNC_READ_ACC, (r < 82 && grid_now > 0)
                 ? 10'($urandom_range(0, (grid_now > 1024 ? 1024 : grid_now) - 1))
                 : 10'($urandom),
                 3'($urandom), 16'($urandom), 17'($urandom), 16'($urandom), $urandom,
                 1'($urandom));
        end else if (r < 88) begin
            send(FUNC_CLEAR_ACC, 10'($urandom), 3'($urandom), 16'($urandom),
                 17'($urandom), 16'($urandom), $urandom, 1'($urandom));
        end else if (r < 92) begin
            send(3'($urandom_range(6, 7)), 10'($urandom), 3'($urandom), 16'($urandom),
                 17'($urandom), 16'($urandom), $urandom, 1'($urandom));
        end else begin
            send(($urandom_range(0, 1) == 0) ? FUNC_MULT : FUNC_TRANSPOSE, 10'($urandom),
                 3'($urandom), 16'($urandom), 17'($urandom), 16'($urandom), $urandom, 1'b0);
        end
    endtask

    initial begin
        int phase_grid[8];
        int phase_dims[8];
        int phase_len;
        phase_grid = '{1, 16, 7, 3, 32, 12, 2, 30};
        phase_dims = '{1, 8, 3, 15, 2, 5, 0, 4};
        gaps_on        = 1'b0;
        grid_now       = 1;
        dims_now       = 1;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_func         = FUNC_LOAD_LEVEL;
        i_grid_point   = '0;
        i_dimension    = '0;
        i_coordinate   = '0;
        i_level_scale  = '0;
        i_level_offset = '0;
        i_value        = '0;
        i_last_dim     = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_GRID_COUNT;
        i_cfg_data     = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Evaluations never use more grid points than the ones given defined values here.
        for (int g = 0; g < LOADED_POINTS; g++) begin
            for (int d = 0; d < 8; d++) random_level(10'(g), 3'(d));
            send(FUNC_LOAD_COEF, 10'(g), 3'($urandom), 16'($urandom), 17'($urandom),
                 16'($urandom), $urandom, 1'($urandom));
        end

        set_counts(4, 8);
        data_point(FUNC_MULT, 32'd0, 1);
        data_point(FUNC_MULT, 32'd0, 2);
        send(FUNC_LOAD_LEVEL, 10'd0, 3'd0, 16'd0, 17'd65536, 16'hFFFF, 32'd0, 1'b0);
        send(FUNC_LOAD_LEVEL, 10'd1023, 3'd7, 16'd0, 17'd1, 16'd0, 32'd0, 1'b0);
        send(FUNC_LOAD_COEF, 10'd0, 3'd0, 16'd0, 17'd1, 16'd0, 32'h8000_0000, 1'b0);
        send(FUNC_LOAD_COEF, 10'd1, 3'd0, 16'd0, 17'd1, 16'd0, 32'h7FFF_FFFF, 1'b0);
        set_counts(4, 1);
        data_point(FUNC_MULT, 32'd0, 0);
        data_point(FUNC_TRANSPOSE, 32'h7FFF_FFFF, 0);
        data_point(FUNC_TRANSPOSE, 32'h8000_0000, 2);
        send(FUNC_READ_ACC, 10'd0, 3'd0, 16'd0, 17'd1, 16'd0, 32'd0, 1'b0);
        send(FUNC_READ_ACC, 10'd1023, 3'd0, 16'd0, 17'd1, 16'd0, 32'd0, 1'b0);
        send(FUNC_READ_ACC, 10'd3, 3'd0, 16'd0, 17'd1, 16'd0, 32'd0, 1'b0);
        send(3'd6, 10'd0, 3'd0, 16'd0, 17'd1, 16'd0, 32'd0, 1'b1);
        send(3'd7, 10'd0, 3'd0, 16'd0, 17'd1, 16'd0, 32'd0, 1'b1);
        send(FUNC_MULT, 10'd0, 3'd3, 16'h1234, 17'd1, 16'd0, 32'd0, 1'b0);
        send(FUNC_CLEAR_ACC, 10'd0, 3'd0, 16'd0, 17'd1, 16'd0, 32'd0, 1'b0);
        send(FUNC_READ_ACC, 10'd0, 3'd0, 16'd0, 17'd1, 16'd0, 32'd0, 1'b0);
        set_counts(0, 0);
        data_point(FUNC_MULT, 32'd0, 0);
        data_point(FUNC_TRANSPOSE, 32'h7FFF_FFFF, 0);
        send(FUNC_READ_ACC, 10'd0, 3'd0, 16'd0, 17'd1, 16'd0, 32'd0, 1'b0);
        set_counts(LOADED_POINTS, 15);
        data_point(FUNC_MULT, 32'd0, 0);
        data_point(FUNC_TRANSPOSE, $urandom, 0);
        send(FUNC_READ_ACC, 10'd1023, 3'd0, 16'd0, 17'd1, 16'd0, 32'd0, 1'b0);

        for (int p = 0; p < 8; p++) begin
            set_counts(phase_grid[p], phase_dims[p]);
            gaps_on   = (p != 7);
            phase_len = 12;
            for (int k = 0; k < phase_len; k++) random_item();
            if (p == 3) drain();
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
